[sv/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared assertion wrappers for the line sampler checker
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, masked while reset is active
`define LSPS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent check that also holds while reset is active
`define LSPS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/lsps_pkg.sv]
// ---------------------------------------------------------------------------
// lsps_pkg
// Types, constants and defaults shared by the line sampler modules
// ---------------------------------------------------------------------------
`default_nettype none

package lsps_pkg;

    // parameter defaults
    localparam int DEF_COORD_INT_BITS  = 10;
    localparam int DEF_COORD_FRAC_BITS = 8;
    localparam int DEF_MAX_RUN         = 64;

    // fraction bits of the walk position and the direction
    localparam int WALK_FRAC = 16;
    localparam int UMAG_W    = WALK_FRAC + 1;

    // configuration register widths
    localparam int MAXP_W    = 7;
    localparam int GRID_W    = 10;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 10;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_POINTS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SLICES = 2'd3;

    // configuration reset values
    localparam logic [MAXP_W-1:0] RST_MAX_POINTS = 7'd64;
    localparam logic [GRID_W-1:0] RST_GRID       = 10'd256;

    // step counter start and margin below max_points
    localparam int STEP_START  = 2;
    localparam int STEP_MARGIN = 3;

    typedef struct packed {
        logic [MAXP_W-1:0] max_points;
        logic [GRID_W-1:0] grid_rows;
        logic [GRID_W-1:0] grid_cols;
        logic [GRID_W-1:0] grid_slices;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_SUM,
        ST_SQRT,
        ST_DIV,
        ST_PREP,
        ST_STEP,
        ST_CHECK,
        ST_END
    } back_state_t;

endpackage

`default_nettype wire

[sv/lsps_fifo.sv]
// ---------------------------------------------------------------------------
// lsps_fifo
// Small register queue with push/full and pop/empty
// ---------------------------------------------------------------------------
`default_nettype none

module lsps_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

endmodule

`default_nettype wire

[sv/lsps_front.sv]
// ---------------------------------------------------------------------------
// lsps_front
// Accepts segment requests, flags zero-length ones and queues them
// ---------------------------------------------------------------------------
`default_nettype none

module lsps_front #(
    parameter int COORD_W = 18
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire logic [COORD_W-1:0]   start_x,
    input  wire logic [COORD_W-1:0]   start_y,
    input  wire logic [COORD_W-1:0]   start_z,
    input  wire logic [COORD_W-1:0]   end_x,
    input  wire logic [COORD_W-1:0]   end_y,
    input  wire logic [COORD_W-1:0]   end_z,
    input  wire logic                 seg_pop,
    output logic                      seg_empty,
    output logic [6*COORD_W:0]        seg_data
);

    logic              zero_len;
    logic [6*COORD_W:0] seg_in;

    // zero-length segment: start and end coincide
    assign zero_len = (start_x == end_x) && (start_y == end_y) && (start_z == end_z);
    assign seg_in   = {zero_len, end_z, end_y, end_x, start_z, start_y, start_x};

    lsps_fifo #(
        .WIDTH (6*COORD_W + 1),
        .DEPTH (2)
    ) u_seg_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (seg_in),
        .full  (full),
        .pop   (seg_pop),
        .rdata (seg_data),
        .empty (seg_empty)
    );

endmodule

`default_nettype wire

[sv/lsps_isqrt.sv]
// ---------------------------------------------------------------------------
// lsps_isqrt
// Iterative floor square root, one result bit per cycle
// ---------------------------------------------------------------------------
`default_nettype none

module lsps_isqrt #(
    parameter int IN_W = 38
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [IN_W-1:0]   value,
    output logic                   done,
    output logic [IN_W/2-1:0]      root
);

    localparam int HALF  = IN_W / 2;
    localparam int REM_W = HALF + 3;
    localparam int CNT_W = $clog2(HALF + 1);

    logic [IN_W-1:0]  val_reg;
    logic [REM_W-1:0] rem_reg;
    logic [HALF-1:0]  root_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             take;

    // bring down two bits and try the next root bit
    assign rem_sh = {rem_reg[REM_W-3:0], val_reg[IN_W-1 -: 2]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign take   = (rem_sh >= trial);
    assign done   = done_reg;
    assign root   = root_reg;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(HALF - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            val_reg  <= value;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            val_reg  <= val_reg << 2;
            rem_reg  <= take ? rem_sh - trial : rem_sh;
            root_reg <= {root_reg[HALF-2:0], take};
        end
    end

endmodule

`default_nettype wire

[sv/lsps_div.sv]
// ---------------------------------------------------------------------------
// lsps_div
// Restoring divider for a fraction below or at one, one bit per cycle
// ---------------------------------------------------------------------------
`default_nettype none

module lsps_div #(
    parameter int A_W = 18,
    parameter int B_W = 19,
    parameter int Q_W = 17
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic [A_W-1:0]  dividend,
    input  wire logic [B_W-1:0]  divisor,
    output logic                 done,
    output logic [Q_W-1:0]       quotient
);

    localparam int REM_W = B_W + 1;
    localparam int CNT_W = $clog2(Q_W + 1);

    logic [REM_W-1:0] rem_reg;
    logic [Q_W-1:0]   q_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [REM_W-1:0] rem_cmp;
    logic [REM_W-1:0] div_ext;
    logic             bit_q;

    // first step compares the dividend itself, later steps the doubled remainder
    assign rem_cmp  = (cnt_reg == '0) ? rem_reg : {rem_reg[REM_W-2:0], 1'b0};
    assign div_ext  = REM_W'(divisor);
    assign bit_q    = (rem_cmp >= div_ext);
    assign done     = done_reg;
    assign quotient = q_reg;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(Q_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= REM_W'(dividend);
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= bit_q ? rem_cmp - div_ext : rem_cmp;
            q_reg   <= {q_reg[Q_W-2:0], bit_q};
        end
    end

endmodule

`default_nettype wire

[sv/lsps_back.sv]
// ---------------------------------------------------------------------------
// lsps_back
// Per-segment sequencer: length, unit direction, walk and point output
// ---------------------------------------------------------------------------
`default_nettype none

module lsps_back #(
    parameter int COORD_INT_BITS  = 10,
    parameter int COORD_FRAC_BITS = 8,
    parameter int MAX_RUN         = 64
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire lsps_pkg::cfg_t                         cfg,
    input  wire logic                                   seg_empty,
    input  wire logic [6*(COORD_INT_BITS+COORD_FRAC_BITS):0] seg_data,
    output logic                                        seg_pop,
    input  wire logic                                   out_full,
    output logic                                        out_push,
    output logic [3*(COORD_INT_BITS+COORD_FRAC_BITS):0] out_data
);

    import lsps_pkg::*;

    localparam int W       = COORD_INT_BITS + COORD_FRAC_BITS;
    localparam int SH      = WALK_FRAC - COORD_FRAC_BITS;
    localparam int SH_M1   = (SH > 0) ? SH - 1 : 0;
    localparam int WALK_W  = COORD_INT_BITS + WALK_FRAC + 2;
    localparam int DEL_W   = WALK_W + 1;
    localparam int SUM_W   = 2*W + 2;
    localparam int LEN_W   = W + 1;
    localparam int RND_W   = WALK_W - WALK_FRAC;
    localparam int CMP_W   = (RND_W > GRID_W) ? RND_W : GRID_W;
    localparam int STEP_W  = $clog2(MAX_RUN + 1);
    localparam int LIM_W   = MAXP_W + 1;
    localparam logic [WALK_W-1:0] ROUND_HALF = (SH > 0) ? (WALK_W'(1) << SH_M1) : '0;
    localparam logic [WALK_W-1:0] GRID_HALF  = WALK_W'(1) << (WALK_FRAC - 1);

    back_state_t state_reg;
    back_state_t state_next;

    logic [2:0][W-1:0]        e_reg;
    logic [2:0][W-1:0]        dmag_reg;
    logic [2:0]               dneg_reg;
    logic [2:0][2*W-1:0]      sq_reg;
    logic [2:0][UMAG_W-1:0]   umag_reg;
    logic [2:0][WALK_W-1:0]   walk_reg;
    logic [UMAG_W-1:0]        vec_reg;
    logic [DEL_W-1:0]         del_reg;
    logic [1:0]               axis_reg;
    logic [STEP_W-1:0]        step_reg;

    logic [2:0][W-1:0]        seg_s;
    logic [2:0][W-1:0]        seg_e;
    logic                     seg_zero;
    logic [SUM_W-1:0]         sq_sum;
    logic                     sqrt_start;
    logic                     sqrt_done;
    logic [LEN_W-1:0]         sqrt_root;
    logic                     div_start;
    logic                     div_done;
    logic [1:0]               div_axis;
    logic [UMAG_W-1:0]        div_q;
    logic [2:0][WALK_W-1:0]   step_walk;
    logic [2:0][DEL_W-1:0]    axis_del;
    logic [DEL_W-1:0]         del_max;
    logic [UMAG_W-1:0]        umag_max;
    logic [2:0]               axis_in;
    logic [2:0][W-1:0]        pt_coord;
    logic [2:0][GRID_W-1:0]   bound;
    logic [MAXP_W-1:0]        limit;
    logic                     step_cap;
    logic                     del_ok;
    logic                     load;

    // unpack the queued segment
    assign seg_s    = seg_data[3*W-1:0];
    assign seg_e    = seg_data[6*W-1:3*W];
    assign seg_zero = seg_data[6*W];

    assign bound = {cfg.grid_slices, cfg.grid_cols, cfg.grid_rows};
    assign limit = (cfg.max_points > MAXP_W'(MAX_RUN)) ? MAXP_W'(MAX_RUN) : cfg.max_points;
    assign step_cap = (LIM_W'(step_reg) + LIM_W'(STEP_MARGIN)) >= LIM_W'(limit);
    assign del_ok   = (del_reg >= DEL_W'(vec_reg));

    // sum of squares feeds the root unit directly
    assign sq_sum = SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);

    // per-axis walk step, remaining distance, grid test and rounded point
    always_comb
    begin
        logic [DEL_W-1:0]  diff;
        logic [WALK_W-1:0] tgrid;
        logic [WALK_W-1:0] trnd;
        logic [RND_W-1:0]  rnd;
        logic [WALK_W-1:0] ew;
        for (int i = 0; i < 3; i++)
        begin
            step_walk[i] = dneg_reg[i] ? walk_reg[i] - WALK_W'(umag_reg[i])
                                       : walk_reg[i] + WALK_W'(umag_reg[i]);
            ew           = WALK_W'(e_reg[i]) << SH;
            diff         = {1'b0, ew} - {walk_reg[i][WALK_W-1], walk_reg[i]};
            axis_del[i]  = diff[DEL_W-1] ? -diff : diff;
            tgrid        = walk_reg[i] + GRID_HALF;
            rnd          = tgrid[WALK_W-1:WALK_FRAC];
            axis_in[i]   = !tgrid[WALK_W-1] && (rnd != '0) &&
                           (CMP_W'(rnd) < CMP_W'(bound[i]));
            trnd         = walk_reg[i] + ROUND_HALF;
            pt_coord[i]  = trnd[SH +: W];
        end
    end

    // largest remaining distance and largest direction component
    always_comb
    begin
        del_max = axis_del[0];
        if (axis_del[1] > del_max)
            del_max = axis_del[1];
        if (axis_del[2] > del_max)
            del_max = axis_del[2];
        umag_max = umag_reg[0];
        if (umag_reg[1] > umag_max)
            umag_max = umag_reg[1];
        if (umag_reg[2] > umag_max)
            umag_max = umag_reg[2];
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state and handshakes
    always_comb
    begin
        state_next = state_reg;
        seg_pop    = 1'b0;
        out_push   = 1'b0;
        out_data   = {1'b0, pt_coord[2], pt_coord[1], pt_coord[0]};
        sqrt_start = 1'b0;
        div_start  = 1'b0;
        div_axis   = 2'd0;
        load       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                out_data = {1'b0, seg_s[2], seg_s[1], seg_s[0]};
                if (!seg_empty && !out_full)
                begin
                    seg_pop    = 1'b1;
                    out_push   = 1'b1;
                    load       = 1'b1;
                    state_next = seg_zero ? ST_END : ST_SQUARE;
                end
            end
            ST_SQUARE:
                state_next = ST_SUM;
            ST_SUM:
            begin
                sqrt_start = 1'b1;
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                if (sqrt_done)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                div_axis = axis_reg + 2'd1;
                if (div_done)
                begin
                    if (axis_reg == 2'd2)
                        state_next = ST_PREP;
                    else
                        div_start = 1'b1;
                end
            end
            ST_PREP:
                state_next = ST_STEP;
            ST_STEP:
            begin
                if (!del_ok || step_cap)
                    state_next = ST_END;
                else
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (!(&axis_in))
                    state_next = ST_END;
                else if (!out_full)
                begin
                    out_push   = 1'b1;
                    state_next = ST_STEP;
                end
            end
            ST_END:
            begin
                out_data = {1'b1, e_reg[2], e_reg[1], e_reg[0]};
                if (!out_full)
                begin
                    out_push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // sequencing counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_reg <= '0;
            step_reg <= '0;
        end
        else
        begin
            if (load)
            begin
                axis_reg <= '0;
                step_reg <= STEP_W'(STEP_START);
            end
            else if (state_reg == ST_DIV && div_done)
                axis_reg <= axis_reg + 2'd1;
            else if (state_reg == ST_CHECK && out_push)
                step_reg <= step_reg + 1'b1;
        end
    end

    // segment datapath
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < 3; i++)
            begin
                e_reg[i]    <= seg_e[i];
                dneg_reg[i] <= (seg_e[i] < seg_s[i]);
                dmag_reg[i] <= (seg_e[i] < seg_s[i]) ? seg_s[i] - seg_e[i]
                                                     : seg_e[i] - seg_s[i];
                walk_reg[i] <= WALK_W'(seg_s[i]) << SH;
            end
        end
        if (state_reg == ST_SQUARE)
        begin
            for (int i = 0; i < 3; i++)
                sq_reg[i] <= dmag_reg[i] * dmag_reg[i];
        end
        if (state_reg == ST_DIV && div_done)
            umag_reg[axis_reg] <= div_q;
        if (state_reg == ST_PREP)
        begin
            vec_reg <= umag_max;
            del_reg <= del_max;
        end
        if (state_reg == ST_STEP && del_ok && !step_cap)
            walk_reg <= step_walk;
        if (state_reg == ST_CHECK && out_push)
            del_reg <= del_max;
    end

    lsps_isqrt #(
        .IN_W (SUM_W)
    ) u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .value (sq_sum),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    lsps_div #(
        .A_W (W),
        .B_W (LEN_W),
        .Q_W (UMAG_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dmag_reg[div_axis]),
        .divisor  (sqrt_root),
        .done     (div_done),
        .quotient (div_q)
    );

endmodule

`default_nettype wire

[sv/line_segment_point_sampler_3d.sv]
// ---------------------------------------------------------------------------
// line_segment_point_sampler_3d
// Samples a 3D segment into unit-step points between its endpoints
// ---------------------------------------------------------------------------
// Each pushed segment yields its start point, then unit steps toward the
// end, then the end point with last_point set. Segments wait in a two-entry
// queue while the back end works on one segment at a time. A segment goes
// through bookkeeping (load with the start point, square, sum, direction
// prep), the length square root (one bit per cycle), the three direction
// divisions on a single shared divider (17 quotient bits each), then per
// step point an add, then the grid test and output, then the step test that
// ends the walk (or the grid test ends it) and the end point. The default
// format is Q10.8, and with the default limits a segment yields at most 59
// step points. The back end stalls while the result queue is full. A
// zero-length segment goes from its start point straight to its end point.
// Results leave through a two-entry queue, so the back end keeps going
// while one waits.
// ---------------------------------------------------------------------------
`default_nettype none

module line_segment_point_sampler_3d #(
    parameter int COORD_INT_BITS  = lsps_pkg::DEF_COORD_INT_BITS,
    parameter int COORD_FRAC_BITS = lsps_pkg::DEF_COORD_FRAC_BITS,
    parameter int MAX_RUN         = lsps_pkg::DEF_MAX_RUN
) (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire logic                                      push,
    output logic                                           full,
    input  wire logic [COORD_INT_BITS+COORD_FRAC_BITS-1:0] start_x,
    input  wire logic [COORD_INT_BITS+COORD_FRAC_BITS-1:0] start_y,
    input  wire logic [COORD_INT_BITS+COORD_FRAC_BITS-1:0] start_z,
    input  wire logic [COORD_INT_BITS+COORD_FRAC_BITS-1:0] end_x,
    input  wire logic [COORD_INT_BITS+COORD_FRAC_BITS-1:0] end_y,
    input  wire logic [COORD_INT_BITS+COORD_FRAC_BITS-1:0] end_z,
    input  wire logic                                      pop,
    output logic                                           empty,
    output logic [COORD_INT_BITS+COORD_FRAC_BITS-1:0]      point_x,
    output logic [COORD_INT_BITS+COORD_FRAC_BITS-1:0]      point_y,
    output logic [COORD_INT_BITS+COORD_FRAC_BITS-1:0]      point_z,
    output logic                                           last_point,
    input  wire logic                                      cfg_valid,
    output logic                                           cfg_ready,
    input  wire logic [lsps_pkg::CFG_IDX_W-1:0]            cfg_index,
    input  wire logic [lsps_pkg::CFG_DAT_W-1:0]            cfg_data
);

    import lsps_pkg::*;

    localparam int W = COORD_INT_BITS + COORD_FRAC_BITS;

    cfg_t          cfg_reg;
    logic          seg_empty;
    logic          seg_pop;
    logic [6*W:0]  seg_data;
    logic          out_full;
    logic          out_push;
    logic [3*W:0]  out_data;
    logic [3*W:0]  res_data;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_points  <= RST_MAX_POINTS;
            cfg_reg.grid_rows   <= RST_GRID;
            cfg_reg.grid_cols   <= RST_GRID;
            cfg_reg.grid_slices <= RST_GRID;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MAX_POINTS:  cfg_reg.max_points  <= cfg_data[MAXP_W-1:0];
                CFG_GRID_ROWS:   cfg_reg.grid_rows   <= cfg_data[GRID_W-1:0];
                CFG_GRID_COLS:   cfg_reg.grid_cols   <= cfg_data[GRID_W-1:0];
                CFG_GRID_SLICES: cfg_reg.grid_slices <= cfg_data[GRID_W-1:0];
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    lsps_front #(
        .COORD_W (W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .start_x   (start_x),
        .start_y   (start_y),
        .start_z   (start_z),
        .end_x     (end_x),
        .end_y     (end_y),
        .end_z     (end_z),
        .seg_pop   (seg_pop),
        .seg_empty (seg_empty),
        .seg_data  (seg_data)
    );

    lsps_back #(
        .COORD_INT_BITS  (COORD_INT_BITS),
        .COORD_FRAC_BITS (COORD_FRAC_BITS),
        .MAX_RUN         (MAX_RUN)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .seg_empty (seg_empty),
        .seg_data  (seg_data),
        .seg_pop   (seg_pop),
        .out_full  (out_full),
        .out_push  (out_push),
        .out_data  (out_data)
    );

    // result queue
    lsps_fifo #(
        .WIDTH (3*W + 1),
        .DEPTH (2)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (out_data),
        .full  (out_full),
        .pop   (pop),
        .rdata (res_data),
        .empty (empty)
    );

    assign point_x    = res_data[W-1:0];
    assign point_y    = res_data[2*W-1:W];
    assign point_z    = res_data[3*W-1:2*W];
    assign last_point = res_data[3*W];

endmodule

`default_nettype wire

[sv/lsps_checker.sv]
// ---------------------------------------------------------------------------
// lsps_checker
// Port-level checks on the line sampler, attached by bind
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lsps_checker (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire logic full,
    input  wire logic pop,
    input  wire logic empty,
    input  wire logic last_point
);

    logic [3:0] pending_reg;
    logic       seg_in;
    logic       seg_out;

    assign seg_in  = push && !full;
    assign seg_out = pop && !empty && last_point;

    // segments accepted whose end point has not been taken yet
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else if (seg_in && !seg_out)
            pending_reg <= pending_reg + 1'b1;
        else if (seg_out && !seg_in)
            pending_reg <= pending_reg - 1'b1;
    end

    // a result only exists for a segment still in flight
    `LSPS_ASSERT(a_result_has_segment, clk, rst_n, (!empty |-> (pending_reg != 4'd0)), "result with no segment in flight")

    // leaving reset finds the result queue empty and the segment queue not full
    `LSPS_ASSERT_ALWAYS(a_reset_queues, clk, ($rose(rst_n) |-> (empty && !full)), "queues not empty after reset")

    // a waiting result keeps its end marker
    `LSPS_ASSERT(a_head_holds, clk, rst_n, ((!empty && !pop) |=> $stable(last_point)), "waiting result changed")

endmodule

bind line_segment_point_sampler_3d lsps_checker u_lsps_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .pop        (pop),
    .empty      (empty),
    .last_point (last_point)
);

`default_nettype wire
